FILE: rtl/core/rllf_pkg.sv
// shared types, codes and timer helpers for the repeater login link controller
// no dependencies; imported by every module of the block
`default_nettype none

package rllf_pkg;

   // message list depth per tick and its index/count widths
   localparam int MaxMsg   = 4;
   localparam int MsgIdxW  = $clog2(MaxMsg);
   localparam int MsgCntW  = $clog2(MaxMsg + 1);
   localparam int CountW   = 17;
   localparam logic [CountW-1:0] CountMax = '1;

   // link phases
   localparam logic [2:0] PhConnect = 3'd0;
   localparam logic [2:0] PhLogin   = 3'd1;
   localparam logic [2:0] PhAuth    = 3'd2;
   localparam logic [2:0] PhConfig  = 3'd3;
   localparam logic [2:0] PhOptions = 3'd4;
   localparam logic [2:0] PhRunning = 3'd5;

   // outgoing message kinds
   localparam logic [2:0] MsgNone    = 3'd0;
   localparam logic [2:0] MsgLogin   = 3'd1;
   localparam logic [2:0] MsgAuth    = 3'd2;
   localparam logic [2:0] MsgConfig  = 3'd3;
   localparam logic [2:0] MsgOptions = 3'd4;
   localparam logic [2:0] MsgPing    = 3'd5;
   localparam logic [2:0] MsgClose   = 3'd6;

   // received packet kinds
   localparam logic [2:0] PktData   = 3'd0;
   localparam logic [2:0] PktNak    = 3'd1;
   localparam logic [2:0] PktAck    = 3'd2;
   localparam logic [2:0] PktClose  = 3'd3;
   localparam logic [2:0] PktPong   = 3'd4;
   localparam logic [2:0] PktBeacon = 3'd5;

   // register indexes
   localparam logic [1:0] CsrOptionsPresent = 2'd0;
   localparam logic [1:0] CsrForwardEnabled = 2'd1;
   localparam logic [1:0] CsrRetryPeriod    = 2'd2;
   localparam logic [1:0] CsrTimeoutPeriod  = 2'd3;

   typedef struct packed {
      logic              options_present;
      logic              forward_enabled;
      logic [15:0]       retry_period_ms;
      logic [CountW-1:0] timeout_period_ms;
   } csr_type;

   typedef struct packed {
      logic       func;
      logic [2:0] packet_kind;
      logic [9:0] elapsed_ms;
      logic       open_ok;
      logic       send_ok;
      logic       read_fail;
   } req_item_type;

   typedef struct packed {
      logic [2:0]        phase;
      logic [CountW-1:0] retry_count;
      logic              retry_running;
      logic [CountW-1:0] timeout_count;
      logic              timeout_running;
   } link_state_type;

   typedef struct packed {
      logic [MsgCntW-1:0]          cnt;
      logic [MaxMsg-1:0][2:0]      kind;
      logic [MaxMsg-1:0][2:0]      phase;
      logic [2:0]                  final_phase;
      logic                        deliver;
      logic                        beacon;
   } tick_result_type;

   // running timer adds elapsed time, saturating
   function automatic logic [CountW-1:0] timer_clock(
      input logic [CountW-1:0] count,
      input logic              running,
      input logic [9:0]        ms
   );
      logic [CountW:0] sum;
      sum = {1'b0, count} + (CountW + 1)'(ms);
      if (!running) begin
         return count;
      end else if (sum > {1'b0, CountMax}) begin
         return CountMax;
      end else begin
         return sum[CountW-1:0];
      end
   endfunction

   function automatic logic timer_expired(
      input logic [CountW-1:0] count,
      input logic              running,
      input logic [CountW-1:0] period
   );
      return running && (period != '0) &&
             (({1'b0, count} + (CountW + 1)'(1)) >= {1'b0, period});
   endfunction

   function automatic link_state_type retry_start(input link_state_type st);
      link_state_type r;
      r = st;
      r.retry_running = 1'b1;
      r.retry_count   = '0;
      return r;
   endfunction

   function automatic link_state_type timeout_start(input link_state_type st);
      link_state_type r;
      r = st;
      r.timeout_running = 1'b1;
      r.timeout_count   = '0;
      return r;
   endfunction

   // back to connect, timeout stopped, retry restarted
   function automatic link_state_type reopen(input link_state_type st);
      link_state_type r;
      r = st;
      r.phase           = PhConnect;
      r.timeout_running = 1'b0;
      r.timeout_count   = '0;
      r.retry_running   = 1'b1;
      r.retry_count     = '0;
      return r;
   endfunction

   // append one message with the phase it was issued in
   function automatic tick_result_type push_msg(
      input tick_result_type res,
      input logic [2:0]      kind,
      input logic [2:0]      phase
   );
      tick_result_type r;
      r = res;
      if (res.cnt < MsgCntW'(MaxMsg)) begin
         r.kind[res.cnt[MsgIdxW-1:0]]  = kind;
         r.phase[res.cnt[MsgIdxW-1:0]] = phase;
         r.cnt = res.cnt + MsgCntW'(1);
      end
      return r;
   endfunction

   function automatic logic [2:0] phase_message(input logic [2:0] ph);
      logic [2:0] m;
      unique case (ph)
         PhLogin:   m = MsgLogin;
         PhAuth:    m = MsgAuth;
         PhConfig:  m = MsgConfig;
         PhOptions: m = MsgOptions;
         PhRunning: m = MsgPing;
         default:   m = MsgNone;
      endcase
      return m;
   endfunction

endpackage

`default_nettype wire

FILE: rtl/core/repeater_login_link_fsm_top.sv
// top level of the repeater login link controller: input register, link state,
// configuration registers; uses rllf_pkg, rllf_core and rllf_rsp_queue
`default_nettype none

// Client side of a repeater-to-master login handshake. Each request word is one
// tick (elapsed milliseconds, optional classified packet, socket flags). The
// block walks the link through connect, login, authorise, config, options and
// running, runs the retry and timeout timers, and answers each tick with one or
// two response words: one per message to send (login, auth, config, options,
// ping, close), or a single word with send kind "none" if nothing is sent. The
// word with tlast set carries the phase after the tick plus the data-forward and
// beacon flags; earlier words carry the phase the message was issued in. A tick
// is registered, evaluated by combinational logic and loaded into a result
// buffer, whose readout, stalled by the response side, sets the rate.
// A new tick is taken while the previous one's words are still draining. The
// configuration port is always ready and must be written only while idle.
module repeater_login_link_fsm_top (
   input  wire         clock,
   input  wire         reset,
   // request stream
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [15:0] req_tdata,   // elapsed_ms[9:0], open_ok[10], send_ok[11],
                                    // read_fail[12], zero[15:13]
   input  wire  [3:0]  req_tuser,   // func[0], packet_kind[3:1]
   // response stream
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [7:0]  rsp_tdata,   // link_state[2:0], deliver_data[3],
                                    // beacon_request[4], zero[7:5]
   output logic [2:0]  rsp_tuser,   // send_kind[2:0]
   output logic        rsp_tlast,
   // register writes
   input  wire         csr_valid,
   output logic        csr_ready,
   input  wire  [1:0]  csr_index,
   input  wire  [16:0] csr_data
);
   import rllf_pkg::*;

   // input register
   logic            in_valid_ff;
   req_item_type    in_ff;
   req_item_type    in_item;

   // link state and registers
   link_state_type  state_ff;
   link_state_type  state_in;
   csr_type         csr_ff;

   tick_result_type res;
   logic            q_free;
   logic            load;

   // unpack the request word
   assign in_item.func        = req_tuser[0];
   assign in_item.packet_kind = req_tuser[3:1];
   assign in_item.elapsed_ms  = req_tdata[9:0];
   assign in_item.open_ok     = req_tdata[10];
   assign in_item.send_ok     = req_tdata[11];
   assign in_item.read_fail   = req_tdata[12];

   // a held tick moves on as soon as the result buffer can take it
   assign load       = in_valid_ff && q_free;
   assign req_tready = !in_valid_ff || load;
   assign csr_ready  = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_ff <= in_item;
      end
   end

   // link state advances once per tick, when its words are loaded
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.phase           <= PhConnect;
         state_ff.retry_count     <= '0;
         state_ff.retry_running   <= 1'b1;
         state_ff.timeout_count   <= '0;
         state_ff.timeout_running <= 1'b0;
      end else if (load) begin
         state_ff <= state_in;
      end
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff.options_present   <= 1'b0;
         csr_ff.forward_enabled   <= 1'b0;
         csr_ff.retry_period_ms   <= 16'd10000;
         csr_ff.timeout_period_ms <= 17'd60000;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CsrOptionsPresent: csr_ff.options_present   <= csr_data[0];
            CsrForwardEnabled: csr_ff.forward_enabled   <= csr_data[0];
            CsrRetryPeriod:    csr_ff.retry_period_ms   <= csr_data[15:0];
            CsrTimeoutPeriod:  csr_ff.timeout_period_ms <= csr_data;
            default: begin
            end
         endcase
      end
   end

   rllf_core u_core (
      .cfg  (csr_ff),
      .cur  (state_ff),
      .item (in_ff),
      .nxt  (state_in),
      .res  (res)
   );

   rllf_rsp_queue u_rsp_queue (
      .clock      (clock),
      .reset      (reset),
      .load       (load),
      .res_in     (res),
      .free       (q_free),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   // the timeout timer never runs while connecting
   a_connect_no_timeout: assert property (@(posedge clock) disable iff (reset)
      state_ff.phase == PhConnect |-> !state_ff.timeout_running)
      else $error("timeout timer running in connect phase");

   // phase stays within the defined phases
   a_phase_range: assert property (@(posedge clock) disable iff (reset)
      state_ff.phase <= PhRunning)
      else $error("link phase out of range");

   // forward and beacon flags only on the closing word of a tick
   a_flags_on_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tlast |-> rsp_tdata[4:3] == 2'b00)
      else $error("flags set before the last word");

   // a loaded tick shows a word in the next cycle
   a_load_shows: assert property (@(posedge clock) disable iff (reset)
      load |=> rsp_tvalid)
      else $error("loaded tick not presented");

   // a waiting tick is not dropped
   a_hold_tick: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !load |=> in_valid_ff)
      else $error("held tick lost");

endmodule

`default_nettype wire

FILE: rtl/core/rllf_core.sv
// one-tick next-state and message list logic of the link controller
// depends on rllf_pkg
`default_nettype none

module rllf_core (
   input  wire  rllf_pkg::csr_type         cfg,
   input  wire  rllf_pkg::link_state_type  cur,
   input  wire  rllf_pkg::req_item_type    item,
   output rllf_pkg::link_state_type        nxt,
   output rllf_pkg::tick_result_type       res
);
   import rllf_pkg::*;

   link_state_type  st;
   tick_result_type r;
   logic            halt;
   logic            ack_hit;
   logic [2:0]      m;

   always_comb begin
      st      = cur;
      r       = '0;
      halt    = 1'b0;
      ack_hit = 1'b0;
      m       = MsgNone;

      if (st.phase == PhConnect) begin
         // only the retry timer runs while connecting
         st.retry_count = timer_clock(st.retry_count, st.retry_running, item.elapsed_ms);
         if (timer_expired(st.retry_count, st.retry_running,
                           {1'b0, cfg.retry_period_ms})) begin
            if (item.open_ok) begin
               r = push_msg(r, MsgLogin, st.phase);
               if (item.send_ok) begin
                  st.phase = PhLogin;
                  st = timeout_start(st);
               end else begin
                  st = reopen(st);
               end
            end
            st = retry_start(st);
         end
      end else if (item.read_fail) begin
         // read failure beats any packet
         if (st.phase == PhRunning) begin
            r = push_msg(r, MsgClose, st.phase);
         end
         st = reopen(st);
      end else begin
         if (item.func) begin
            unique case (item.packet_kind)
               PktData: begin
                  r.deliver = cfg.forward_enabled;
               end
               PktNak: begin
                  if (st.phase == PhRunning) begin
                     st.phase = PhLogin;
                     st = timeout_start(st);
                     st = retry_start(st);
                  end else begin
                     st   = reopen(st);
                     halt = 1'b1;
                  end
               end
               PktAck: begin
                  ack_hit = 1'b1;
                  unique case (st.phase)
                     PhLogin: begin
                        r = push_msg(r, MsgAuth, st.phase);
                        if (!item.send_ok) begin
                           st = reopen(st);
                        end
                        st.phase = PhAuth;
                     end
                     PhAuth: begin
                        r = push_msg(r, MsgConfig, st.phase);
                        if (!item.send_ok) begin
                           st = reopen(st);
                        end
                        st.phase = PhConfig;
                     end
                     PhConfig: begin
                        if (cfg.options_present) begin
                           r = push_msg(r, MsgOptions, st.phase);
                           if (!item.send_ok) begin
                              st = reopen(st);
                           end
                           st.phase = PhOptions;
                        end else begin
                           st.phase = PhRunning;
                        end
                     end
                     PhOptions: begin
                        st.phase = PhRunning;
                     end
                     default: begin
                        ack_hit = 1'b0;
                     end
                  endcase
                  if (ack_hit) begin
                     st = timeout_start(st);
                     st = retry_start(st);
                  end
               end
               PktClose: begin
                  if (st.phase == PhRunning) begin
                     r = push_msg(r, MsgClose, st.phase);
                  end
                  st = reopen(st);
               end
               PktPong: begin
                  st = timeout_start(st);
               end
               PktBeacon: begin
                  r.beacon = 1'b1;
               end
               default: begin
               end
            endcase
         end

         if (!halt) begin
            // retry timer: resend the pending request or ping
            st.retry_count = timer_clock(st.retry_count, st.retry_running, item.elapsed_ms);
            if (timer_expired(st.retry_count, st.retry_running,
                              {1'b0, cfg.retry_period_ms})) begin
               m = phase_message(st.phase);
               if (m != MsgNone) begin
                  r = push_msg(r, m, st.phase);
                  if (!item.send_ok) begin
                     st = reopen(st);
                  end
               end
               st = retry_start(st);
            end
            // timeout timer: drop the link
            st.timeout_count = timer_clock(st.timeout_count, st.timeout_running,
                                           item.elapsed_ms);
            if (timer_expired(st.timeout_count, st.timeout_running,
                              cfg.timeout_period_ms)) begin
               if (st.phase == PhRunning) begin
                  r = push_msg(r, MsgClose, st.phase);
               end
               st = reopen(st);
            end
         end
      end

      // a tick always gives at least one word
      if (r.cnt == '0) begin
         r.cnt = MsgCntW'(1);
      end
      r.final_phase = st.phase;
   end

   assign nxt = st;
   assign res = r;

endmodule

`default_nettype wire

FILE: rtl/core/rllf_rsp_queue.sv
// result buffer: holds one tick's message list and plays it out one word a cycle
// while the response side is ready; depends on rllf_pkg
`default_nettype none

module rllf_rsp_queue (
   input  wire                             clock,
   input  wire                             reset,
   input  wire                             load,
   input  wire  rllf_pkg::tick_result_type res_in,
   output logic                            free,
   output logic                            rsp_tvalid,
   input  wire                             rsp_tready,
   output logic [7:0]                      rsp_tdata,   // link_state[2:0], deliver_data[3],
                                                        // beacon_request[4], zero[7:5]
   output logic [2:0]                      rsp_tuser,   // send_kind[2:0]
   output logic                            rsp_tlast
);
   import rllf_pkg::*;

   logic                valid_ff;
   logic [MsgIdxW-1:0]  idx_ff;
   tick_result_type     res_ff;
   logic                at_last;
   logic [2:0]          phase_out;

   assign at_last = ((MsgCntW'(idx_ff) + MsgCntW'(1)) == res_ff.cnt);
   assign free    = !valid_ff || (rsp_tready && at_last);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= '0;
      end else if (load) begin
         valid_ff <= 1'b1;
         idx_ff   <= '0;
      end else if (valid_ff && rsp_tready) begin
         if (at_last) begin
            valid_ff <= 1'b0;
         end else begin
            idx_ff <= idx_ff + MsgIdxW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         res_ff <= res_in;
      end
   end

   // the last word reports the phase after the tick
   assign phase_out  = at_last ? res_ff.final_phase : res_ff.phase[idx_ff];
   assign rsp_tvalid = valid_ff;
   assign rsp_tuser  = res_ff.kind[idx_ff];
   assign rsp_tdata  = {3'b000, at_last & res_ff.beacon, at_last & res_ff.deliver, phase_out};
   assign rsp_tlast  = at_last;

endmodule

`default_nettype wire

FILE: tb/tb_top.sv
// self-checking testbench for repeater_login_link_fsm_top: drives tick words,
// predicts the message words of every tick and compares them as they arrive
// depends on rllf_pkg (codes, register indexes, request item type) and the rtl
`timescale 1ns / 1ps

module tb_top;
   import rllf_pkg::*;

   // packet kinds the block does not act on
   localparam logic [2:0] PktOther = 3'd6;
   localparam logic [2:0] PktSpare = 3'd7;

   // cycles without any handshake before the run is declared hung
   localparam int QuietLimit = 1000;
   // settle time after the last response word of a phase
   localparam int DrainCycles = 6;

   // one response word, fields in the order they are checked
   typedef struct packed {
      logic [2:0] send_kind;
      logic [2:0] link_state;
      logic       deliver_data;
      logic       beacon_request;
      logic       last;
   } rsp_word_type;

   // link controller prediction: own copy of registers, phase and timers;
   // each accepted tick queues its message words, each response word is
   // checked against the oldest one
   class login_link_scoreboard;
      bit        opt_present;
      bit        fwd_enabled;
      bit [15:0] retry_period;
      bit [16:0] timeout_period;
      bit [2:0]  phase;
      bit [16:0] retry_cnt;
      bit        retry_run;
      bit [16:0] timeout_cnt;
      bit        timeout_run;
      // messages issued during the tick being predicted
      bit [2:0]  sent_kind[MaxMsg];
      bit [2:0]  sent_phase[MaxMsg];
      int        sent_n;
      bit        send_good;
      bit        deliver_flag;
      bit        beacon_flag;
      rsp_word_type pending_words[$];
      int        errors;

      function new();
         opt_present    = 1'b0;
         fwd_enabled    = 1'b0;
         retry_period   = 16'd10000;
         timeout_period = 17'd60000;
         phase          = PhConnect;
         retry_cnt      = '0;
         retry_run      = 1'b1;
         timeout_cnt    = '0;
         timeout_run    = 1'b0;
         errors         = 0;
      endfunction

      function void write_reg(logic [1:0] idx, logic [16:0] val);
         case (idx)
            CsrOptionsPresent: opt_present    = val[0];
            CsrForwardEnabled: fwd_enabled    = val[0];
            CsrRetryPeriod:    retry_period   = val[15:0];
            CsrTimeoutPeriod:  timeout_period = val;
            default: ;
         endcase
      endfunction

      // saturating millisecond count
      function bit [16:0] clock_count(bit [16:0] cnt, bit run, bit [9:0] ms);
         bit [17:0] sum;
         sum = {1'b0, cnt} + 18'(ms);
         if (!run) return cnt;
         return (sum > 18'h1FFFF) ? 17'h1FFFF : sum[16:0];
      endfunction

      function bit expired(bit [16:0] cnt, bit run, bit [16:0] period);
         return run && (period != '0) && (({1'b0, cnt} + 18'd1) >= {1'b0, period});
      endfunction

      function void restart_retry();
         retry_run = 1'b1;
         retry_cnt = '0;
      endfunction

      function void restart_timeout();
         timeout_run = 1'b1;
         timeout_cnt = '0;
      endfunction

      function void reopen_link();
         phase       = PhConnect;
         timeout_run = 1'b0;
         timeout_cnt = '0;
         restart_retry();
      endfunction

      // records a message, a failed send drops the link
      function bit issue(bit [2:0] kind);
         if (sent_n < MaxMsg) begin
            sent_kind[sent_n]  = kind;
            sent_phase[sent_n] = phase;
            sent_n++;
         end
         if (!send_good) begin
            reopen_link();
            return 1'b0;
         end
         return 1'b1;
      endfunction

      function void close_link();
         if (phase == PhRunning) void'(issue(MsgClose));
         reopen_link();
      endfunction

      function bit [2:0] retry_message(bit [2:0] ph);
         case (ph)
            PhLogin:   return MsgLogin;
            PhAuth:    return MsgAuth;
            PhConfig:  return MsgConfig;
            PhOptions: return MsgOptions;
            PhRunning: return MsgPing;
            default:   return MsgNone;
         endcase
      endfunction

      // the phase moves on even when the send fails
      function void take_ack();
         case (phase)
            PhLogin: begin
               void'(issue(MsgAuth));
               phase = PhAuth;
            end
            PhConfig: begin
               if (opt_present) begin
                  void'(issue(MsgOptions));
                  phase = PhOptions;
               end else begin
                  phase = PhRunning;
               end
            end
            PhAuth: begin
               void'(issue(MsgConfig));
               phase = PhConfig;
            end
            PhOptions: phase = PhRunning;
            default: return;
         endcase
         restart_timeout();
         restart_retry();
      endfunction

      function void advance(req_item_type t);
         bit [2:0] m;
         if (phase == PhConnect) begin
            retry_cnt = clock_count(retry_cnt, retry_run, t.elapsed_ms);
            if (expired(retry_cnt, retry_run, {1'b0, retry_period})) begin
               if (t.open_ok) begin
                  if (!issue(MsgLogin)) return;
                  phase = PhLogin;
                  restart_timeout();
               end
               restart_retry();
            end
            return;
         end
         if (t.read_fail) begin
            close_link();
            return;
         end
         if (t.func) begin
            case (t.packet_kind)
               PktData:   deliver_flag = fwd_enabled;
               PktNak: begin
                  if (phase == PhRunning) begin
                     phase = PhLogin;
                     restart_timeout();
                     restart_retry();
                  end else begin
                     close_link();
                     return;
                  end
               end
               PktAck:    take_ack();
               PktClose:  close_link();
               PktPong:   restart_timeout();
               PktBeacon: beacon_flag = 1'b1;
               default: ;
            endcase
         end
         retry_cnt = clock_count(retry_cnt, retry_run, t.elapsed_ms);
         if (expired(retry_cnt, retry_run, {1'b0, retry_period})) begin
            m = retry_message(phase);
            if (m != MsgNone) void'(issue(m));
            restart_retry();
         end
         timeout_cnt = clock_count(timeout_cnt, timeout_run, t.elapsed_ms);
         if (expired(timeout_cnt, timeout_run, timeout_period)) close_link();
      endfunction

      function void note_tick(req_item_type t);
         rsp_word_type w;
         int           n;
         sent_n       = 0;
         send_good    = t.send_ok;
         deliver_flag = 1'b0;
         beacon_flag  = 1'b0;
         advance(t);
         n = sent_n;
         if (n == 0) begin
            sent_kind[0] = MsgNone;
            n = 1;
         end
         for (int k = 0; k < n; k++) begin
            w.last           = (k == n - 1);
            w.send_kind      = sent_kind[k];
            w.link_state     = w.last ? phase : sent_phase[k];
            w.deliver_data   = w.last && deliver_flag;
            w.beacon_request = w.last && beacon_flag;
            pending_words.push_back(w);
         end
      endfunction

      task report(string what);
         $display("%0t mismatch: %s", $realtime, what);
         errors++;
      endtask

      task compare(string name, logic [2:0] got, logic [2:0] want);
         if (got !== want) report($sformatf("%s got %0d want %0d", name, got, want));
      endtask

      task check_word(rsp_word_type got);
         rsp_word_type want;
         if (pending_words.size() == 0) begin
            report($sformatf("word with none pending, kind %0d state %0d",
                             got.send_kind, got.link_state));
            return;
         end
         want = pending_words.pop_front();
         compare("send_kind", got.send_kind, want.send_kind);
         compare("link_state", got.link_state, want.link_state);
         compare("deliver_data", 3'(got.deliver_data), 3'(want.deliver_data));
         compare("beacon_request", 3'(got.beacon_request), 3'(want.beacon_request));
         compare("last", 3'(got.last), 3'(want.last));
      endtask
   endclass

   logic        clock = 1'b0;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [15:0] req_tdata;   // elapsed_ms, open_ok, send_ok, read_fail, zero pad
   logic [3:0]  req_tuser;   // func, packet_kind
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;   // link_state, deliver_data, beacon_request, zero pad
   logic [2:0]  rsp_tuser;   // send_kind
   logic        rsp_tlast;
   logic        csr_valid;
   logic        csr_ready;
   logic [1:0]  csr_index;
   logic [16:0] csr_data;

   login_link_scoreboard sb;
   int idle_pct;      // chance in percent of an idle burst, both sides
   int stall_left;

   repeater_login_link_fsm_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   // 20 ns clock
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // any handshake on any channel keeps the watchdog quiet
   wire any_accept = (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
                     (csr_valid && csr_ready);

   // response side back-pressure: random bursts of stalled cycles
   always @(negedge clock) begin
      if (stall_left > 0) begin
         rsp_tready = 1'b0;
         stall_left--;
      end else if ($urandom_range(0, 99) < idle_pct) begin
         rsp_tready = 1'b0;
         stall_left = $urandom_range(0, 3);
      end else begin
         rsp_tready = 1'b1;
      end
   end

   // every accepted response word goes to the scoreboard
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         sb.check_word({rsp_tuser, rsp_tdata[2:0], rsp_tdata[3], rsp_tdata[4], rsp_tlast});
   end

   // hang detection: too long without any word moving
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < QuietLimit) begin
         @(posedge clock);
         if (any_accept) quiet = 0;
         else quiet++;
      end
      $display("FAIL repeater_login_link_fsm_top");
      $finish;
   end

   // one tick word, with an optional idle burst in front of it; valid stays
   // high from the previous word when there is no burst
   task automatic send_tick(input req_item_type t);
      @(negedge clock);
      if ($urandom_range(0, 99) < idle_pct) begin
         req_tvalid = 1'b0;
         repeat ($urandom_range(1, 4)) @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tdata  = {3'b000, t.read_fail, t.send_ok, t.open_ok, t.elapsed_ms};
      req_tuser  = {t.packet_kind, t.func};
      do @(posedge clock); while (!req_tready);
      sb.note_tick(t);
   endtask

   task automatic send_fields(logic func, logic [2:0] kind, int ms, logic open_ok,
                              logic send_ok, logic read_fail);
      req_item_type t;
      t.func        = func;
      t.packet_kind = kind;
      t.elapsed_ms  = 10'(ms);
      t.open_ok     = open_ok;
      t.send_ok     = send_ok;
      t.read_fail   = read_fail;
      send_tick(t);
   endtask

   task automatic write_csr(logic [1:0] idx, logic [16:0] val);
      @(negedge clock);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_data  = val;
      do @(posedge clock); while (!csr_ready);
      sb.write_reg(idx, val);
   endtask

   // all four registers, only while the block is idle
   task automatic configure(bit opt, bit fwd, int retry_ms, int timeout_ms);
      write_csr(CsrOptionsPresent, 17'(opt));
      write_csr(CsrForwardEnabled, 17'(fwd));
      write_csr(CsrRetryPeriod, 17'(retry_ms));
      write_csr(CsrTimeoutPeriod, 17'(timeout_ms));
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   // stop sending and let every predicted word come out
   task automatic drain();
      @(negedge clock);
      req_tvalid = 1'b0;
      while (sb.pending_words.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
   endtask

   // mostly well-formed traffic for the current phase, some pure noise
   function automatic req_item_type make_tick(int ms_lo, int ms_hi);
      req_item_type t;
      int           pick;
      if ($urandom_range(0, 9) == 0) t.elapsed_ms = 10'($urandom_range(0, 1000));
      else t.elapsed_ms = 10'($urandom_range(ms_lo, ms_hi));
      t.packet_kind = 3'($urandom);
      if ($urandom_range(0, 4) == 0) begin
         t.func      = 1'($urandom);
         t.open_ok   = 1'($urandom);
         t.send_ok   = 1'($urandom);
         t.read_fail = 1'($urandom);
         return t;
      end
      t.open_ok   = ($urandom_range(0, 9) != 0);
      t.send_ok   = ($urandom_range(0, 19) != 0);
      t.read_fail = ($urandom_range(0, 39) == 0);
      t.func      = 1'b1;
      pick = $urandom_range(0, 99);
      if (sb.phase == PhRunning) begin
         // keep-alive traffic with the occasional drop
         if (pick < 25)      t.func = 1'b0;
         else if (pick < 45) t.packet_kind = PktPong;
         else if (pick < 60) t.packet_kind = PktData;
         else if (pick < 70) t.packet_kind = PktBeacon;
         else if (pick < 76) t.packet_kind = PktNak;
         else if (pick < 82) t.packet_kind = PktClose;
         else if (pick < 88) t.packet_kind = PktAck;
         else t.packet_kind = ($urandom_range(0, 1) != 0) ? PktOther : PktSpare;
      end else begin
         // mostly acks so the login sequence gets through
         if (pick < 45)      t.packet_kind = PktAck;
         else if (pick < 60) t.func = 1'b0;
         else if (pick < 70) t.packet_kind = PktData;
         else if (pick < 78) t.packet_kind = PktBeacon;
         else if (pick < 84) t.packet_kind = PktPong;
         else if (pick < 88) t.packet_kind = PktNak;
         else if (pick < 92) t.packet_kind = PktClose;
         else t.packet_kind = ($urandom_range(0, 1) != 0) ? PktOther : PktSpare;
      end
      return t;
   endfunction

   task automatic run_random(int count, int ms_lo, int ms_hi);
      repeat (count) send_tick(make_tick(ms_lo, ms_hi));
      drain();
   endtask

   initial begin
      sb         = new();
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = '0;
      csr_valid  = 1'b0;
      csr_index  = CsrOptionsPresent;
      csr_data   = '0;
      idle_pct   = 20;
      stall_left = 0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // reset register values untouched
      run_random(15, 0, 1000);

      // directed: retry fires on every tick, timeout never does
      idle_pct = 30;
      configure(1'b1, 1'b1, 1, 131071);
      send_fields(1'b0, PktData, 0, 1'b1, 1'b0, 1'b0);     // failed send drops any phase
      send_fields(1'b0, PktData, 0, 1'b0, 1'b1, 1'b0);     // retry fires, open fails
      send_fields(1'b1, PktBeacon, 1000, 1'b1, 1'b0, 1'b1); // login send fails
      send_fields(1'b0, PktData, 0, 1'b1, 1'b1, 1'b0);     // login sent
      send_fields(1'b1, PktAck, 0, 1'b1, 1'b0, 1'b0);      // ack with a failed send
      send_fields(1'b0, PktData, 0, 1'b1, 1'b1, 1'b0);
      send_fields(1'b1, PktAck, 3, 1'b1, 1'b1, 1'b0);      // to authorise
      send_fields(1'b1, PktAck, 0, 1'b1, 1'b1, 1'b0);      // to config
      send_fields(1'b1, PktAck, 0, 1'b1, 1'b1, 1'b0);      // to options
      send_fields(1'b1, PktAck, 0, 1'b1, 1'b1, 1'b0);      // to running, ping
      send_fields(1'b1, PktData, 1, 1'b1, 1'b1, 1'b0);
      send_fields(1'b1, PktBeacon, 2, 1'b1, 1'b1, 1'b0);
      send_fields(1'b1, PktPong, 0, 1'b1, 1'b1, 1'b0);
      send_fields(1'b1, PktSpare, 0, 1'b1, 1'b1, 1'b0);
      send_fields(1'b1, PktOther, 0, 1'b1, 1'b1, 1'b0);
      send_fields(1'b1, PktAck, 0, 1'b1, 1'b1, 1'b0);      // ignored while running
      send_fields(1'b1, PktNak, 0, 1'b1, 1'b1, 1'b0);      // back to login
      send_fields(1'b1, PktNak, 0, 1'b1, 1'b1, 1'b0);      // outside running: reopen
      send_fields(1'b0, PktData, 0, 1'b1, 1'b1, 1'b0);
      send_fields(1'b1, PktClose, 0, 1'b1, 1'b1, 1'b0);    // master close, no close sent
      send_fields(1'b0, PktData, 0, 1'b1, 1'b1, 1'b0);
      send_fields(1'b1, PktData, 0, 1'b1, 1'b1, 1'b1);     // read failure beats the packet
      drain();

      // short periods, full sequences
      idle_pct = 25;
      configure(1'b0, 1'b1, $urandom_range(2, 40), $urandom_range(50, 400));
      run_random(40, 0, 20);

      // timeout of one: a running timeout timer expires at once
      idle_pct = 40;
      configure(1'b1, 1'b0, 2, 1);
      run_random(20, 0, 5);

      // retry on every tick, no idling for a stretch
      idle_pct = 0;
      configure(1'b1, 1'b1, 1, $urandom_range(200, 2000));
      run_random(30, 0, 50);

      // timeout disabled by a zero period
      idle_pct = 30;
      configure(1'b0, 0, $urandom_range(3, 30), 0);
      run_random(25, 0, 10);

      // retry disabled: link falls to connect and the retry count saturates
      idle_pct = 10;
      configure(1'b0, 1'b0, 0, 1);
      run_random(145, 900, 1000);

      // largest periods
      idle_pct = 15;
      configure(1'b1, 1'b1, 65535, 131071);
      run_random(15, 900, 1000);

      // reset period values written back, options on
      idle_pct = 20;
      configure(1'b1, 1'b0, 10000, 60000);
      run_random(15, 500, 1000);

      // final stretch without any idling
      idle_pct = 0;
      configure(1'b1, 1'b1, $urandom_range(2, 50), $urandom_range(100, 2000));
      run_random(40, 0, 30);

      if (sb.errors == 0 && sb.pending_words.size() == 0) begin
         $display("PASS repeater_login_link_fsm_top");
      end else begin
         $display("FAIL repeater_login_link_fsm_top");
      end
      $finish;
   end

endmodule
